// ===== rtl/ksm_pkg.sv =====
// Shared types and constants of the scalar Kalman smoother.
package ksm_pkg;

	localparam int GAIN_FRAC = 24;
	localparam int GAIN_W    = GAIN_FRAC + 1;
	localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PROC_NOISE     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_START_VARIANCE = 2'd3;

	localparam logic [1:0] MODE_LOW_PASS  = 2'd0;
	localparam logic [1:0] MODE_HIGH_PASS = 2'd1;

	localparam logic OP_INIT   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRED,
		ST_DEN,
		ST_DIV,
		ST_MUL,
		ST_DONE
	} ksm_state_t;

endpackage

// ===== rtl/ksm_div.sv =====
// Bit-serial restoring divider producing the Q1.24 gain num*2^24/den.
module ksm_div #(
	parameter int W = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [W-1:0]               num,
	input  logic [W-1:0]               den,
	output logic                       done,
	output logic [ksm_pkg::GAIN_W-1:0] quot
);
	import ksm_pkg::*;

	localparam int CNT_W = $clog2(GAIN_W + 1);

	logic [W:0]        rem_q;
	logic [W-1:0]      den_q;
	logic [GAIN_W-1:0] quot_q;
	logic              zero_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic              ge;
	logic [W:0]        diff;

	always_comb begin
		ge   = rem_q >= {1'b0, den_q};
		diff = ge ? (rem_q - {1'b0, den_q}) : rem_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1)) && !start;
			if (start) begin
				cnt_q <= CNT_W'(GAIN_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// The remainder stays below the divisor, so doubling it fits in W+1 bits.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {1'b0, num};
			den_q  <= den;
			quot_q <= '0;
			zero_q <= (den == '0);
		end else if (cnt_q != '0) begin
			rem_q  <= {diff[W-1:0], 1'b0};
			quot_q <= {quot_q[GAIN_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = zero_q ? '0 : quot_q;

endmodule

// ===== rtl/ksm_mul.sv =====
// Bit-serial shift-and-add multiplier of an unsigned word by a Q1.24 factor.
module ksm_mul #(
	parameter int AW = 25
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [AW-1:0]                 a,
	input  logic [ksm_pkg::GAIN_W-1:0]    b,
	output logic                          done,
	output logic [AW+ksm_pkg::GAIN_W-1:0] prod
);
	import ksm_pkg::*;

	localparam int PW    = AW + GAIN_W;
	localparam int CNT_W = $clog2(GAIN_W + 1);

	logic [AW-1:0]     a_q;
	logic [GAIN_W-1:0] b_q;
	logic [PW-1:0]     acc_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [PW-1:0]     acc_next;

	// Most significant factor bit first: double the sum, then add the multiplicand.
	always_comb begin
		acc_next = {acc_q[PW-2:0], 1'b0} + (b_q[GAIN_W-1] ? PW'(a_q) : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1)) && !start;
			if (start) begin
				cnt_q <= CNT_W'(GAIN_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (cnt_q != '0) begin
			acc_q <= acc_next;
			b_q   <= {b_q[GAIN_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// ===== rtl/scalar_kalman_smoother.sv =====
// Top level of the scalar Kalman smoother: control sequencer, state and output register.
//
//   Channel  Handshake              Payload
//   in       in_valid / in_stall    opcode, sample_value
//   out      out_valid / out_stall  filtered_value
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An init beat is taken in the idle state, which stays ready. A filtered sample passes
// the states PRED and DEN, then DIV for the bit-serial gain divider, then MUL for the
// two bit-serial multipliers that run side by side, and ends in DONE, where it waits
// for the output register. A pass-through sample goes from idle straight to DONE.
// Reset clears the state to zero and loads the default register values. A stalled
// output beat is held in the output register while the next item is already at work.
module scalar_kalman_smoother #(
	parameter int SAMPLE_BITS = 24,
	parameter int VAR_BITS    = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             opcode,
	input  logic signed [SAMPLE_BITS-1:0]    sample_value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [SAMPLE_BITS-1:0]    filtered_value,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ksm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ksm_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import ksm_pkg::*;

	localparam int SB = SAMPLE_BITS;
	localparam int VB = VAR_BITS;
	localparam int EW = SB + 1;

	localparam logic signed [SB+2:0] EST_MAX = {3'b000, 1'b0, {(SB-1){1'b1}}};
	localparam logic signed [SB+2:0] EST_MIN = ~EST_MAX;
	localparam logic signed [SB:0]   HP_MAX  = {2'b00, {(SB-1){1'b1}}};
	localparam logic signed [SB:0]   HP_MIN  = ~HP_MAX;
	localparam logic [EW+GAIN_W:0]   ROUND_HALF = (EW + GAIN_W + 1)'(1) << (GAIN_FRAC - 1);

	ksm_state_t state_q, state_d;

	logic [1:0]           mode_q;
	logic [VB-1:0]        meas_noise_q;
	logic [VB-1:0]        proc_noise_q;
	logic [VB-1:0]        start_var_q;
	logic [VB-1:0]        var_q;
	logic signed [SB-1:0] est_q;
	logic signed [SB-1:0] z_q;
	logic [VB-1:0]        p_q;
	logic [VB-1:0]        den_q;
	logic [EW-1:0]        mag_q;
	logic                 neg_q;
	logic                 out_valid_q;
	logic signed [SB-1:0] out_value_q;

	logic                 accept;
	logic                 load_out;
	logic                 div_start;
	logic                 mul_start;
	logic                 div_done;
	logic [GAIN_W-1:0]    gain;
	logic                 mul_est_done;
	logic                 mul_var_done;
	logic                 mul_done;
	logic [EW+GAIN_W-1:0] prod_est;
	logic [VB+GAIN_W-1:0] prod_var;

	logic [VB+CFG_DATA_W-1:0] cfg_ext;
	logic [VB-1:0]            cfg_var;
	logic [VB:0]              p_sum;
	logic [VB:0]              den_sum;
	logic signed [SB:0]       resid;
	logic [EW+GAIN_W:0]       rounded;
	logic [SB+1:0]            step_mag;
	logic signed [SB+2:0]     est_sum;
	logic signed [SB-1:0]     est_new;
	logic signed [SB:0]       hp_diff;
	logic signed [SB-1:0]     result;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !in_stall;

	// Both multipliers start together and finish in the same cycle.
	assign mul_done = mul_est_done && mul_var_done;

	always_comb begin
		cfg_ext = {{VB{1'b0}}, cfg_data};
		cfg_var = cfg_ext[VB-1:0];
	end

	// Variance sums, which saturate when they are registered, and the signed residual.
	always_comb begin
		p_sum   = {1'b0, var_q} + {1'b0, proc_noise_q};
		den_sum = {1'b0, p_q} + {1'b0, meas_noise_q};
		resid   = {z_q[SB-1], z_q} - {est_q[SB-1], est_q};
	end

	// The step is rounded to nearest, ties away from zero, on its magnitude.
	always_comb begin
		rounded  = {1'b0, prod_est} + ROUND_HALF;
		step_mag = rounded[GAIN_FRAC +: SB+2];
		if (neg_q) begin
			est_sum = {{3{est_q[SB-1]}}, est_q} - $signed({1'b0, step_mag});
		end else begin
			est_sum = {{3{est_q[SB-1]}}, est_q} + $signed({1'b0, step_mag});
		end
		if (est_sum > EST_MAX) begin
			est_new = EST_MAX[SB-1:0];
		end else if (est_sum < EST_MIN) begin
			est_new = EST_MIN[SB-1:0];
		end else begin
			est_new = est_sum[SB-1:0];
		end
	end

	always_comb begin
		hp_diff = {z_q[SB-1], z_q} - {est_q[SB-1], est_q};
		case (mode_q)
			MODE_LOW_PASS: begin
				result = est_q;
			end
			MODE_HIGH_PASS: begin
				if (hp_diff > HP_MAX) begin
					result = HP_MAX[SB-1:0];
				end else if (hp_diff < HP_MIN) begin
					result = HP_MIN[SB-1:0];
				end else begin
					result = hp_diff[SB-1:0];
				end
			end
			default: begin
				result = z_q;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && opcode == OP_SAMPLE) begin
					if (mode_q == MODE_LOW_PASS || mode_q == MODE_HIGH_PASS) begin
						state_d = ST_PRED;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_PRED: begin
				state_d = ST_DEN;
			end
			ST_DEN: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				if (mul_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall  = 1'b1;
		div_start = 1'b0;
		mul_start = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_DEN: begin
				div_start = 1'b1;
			end
			ST_DIV: begin
				mul_start = div_done;
			end
			ST_DONE: begin
				load_out = !out_valid_q || !out_stall;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			mode_q       <= MODE_LOW_PASS;
			meas_noise_q <= VB'(1677722);
			proc_noise_q <= VB'(59794);
			start_var_q  <= VB'(288236);
			var_q        <= '0;
			est_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_FILTER_MODE:    mode_q       <= cfg_data[1:0];
					CFG_MEAS_NOISE:     meas_noise_q <= cfg_var;
					CFG_PROC_NOISE:     proc_noise_q <= cfg_var;
					CFG_START_VARIANCE: start_var_q  <= cfg_var;
					default: begin
					end
				endcase
			end
			if (accept && opcode == OP_INIT) begin
				est_q <= sample_value;
				var_q <= start_var_q;
			end else if (state_q == ST_MUL && mul_done) begin
				est_q <= est_new;
				// The product never exceeds the predicted variance, so no clamp is needed.
				var_q <= prod_var[GAIN_FRAC +: VB];
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			z_q <= sample_value;
		end
		if (state_q == ST_PRED) begin
			p_q   <= p_sum[VB] ? '1 : p_sum[VB-1:0];
			neg_q <= resid[SB];
			mag_q <= resid[SB] ? EW'(-resid) : EW'(resid);
		end
		if (state_q == ST_DEN) begin
			den_q <= den_sum[VB] ? '1 : den_sum[VB-1:0];
		end
		if (load_out) begin
			out_value_q <= result;
		end
	end

	ksm_div #(
		.W (VB)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (p_q),
		.den    (state_q == ST_DEN ? (den_sum[VB] ? {VB{1'b1}} : den_sum[VB-1:0]) : den_q),
		.done   (div_done),
		.quot   (gain)
	);

	ksm_mul #(
		.AW (EW)
	) u_mul_est (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mag_q),
		.b      (gain),
		.done   (mul_est_done),
		.prod   (prod_est)
	);

	ksm_mul #(
		.AW (VB)
	) u_mul_var (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (p_q),
		.b      (GAIN_ONE - gain),
		.done   (mul_var_done),
		.prod   (prod_var)
	);

	assign out_valid      = out_valid_q;
	assign filtered_value = out_value_q;

endmodule
